@@ rtl/mandelbrot_escape_time_macros.svh @@
// Assertion macros shared by the escape-time RTL.
// Used by met_ctrl and met_dp; no other dependencies.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define MET_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at each rising edge outside reset.
`define MET_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/met_pkg.sv @@
// Shared types and constants for the Mandelbrot escape-time block.
// No dependencies; imported by met_ctrl, met_dp and the top level.
package met_pkg;

  // Width of one coordinate on the input port.
  localparam int COORD_WIDTH = 32;
  // Default number of fraction bits of a coordinate.
  localparam int MET_FRAC_BITS = 28;
  // Width of the iteration counter and the limit register.
  localparam int CNT_W = 16;
  // Iteration limit after reset.
  localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(256);

  // One input point.
  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] c_real;
    logic signed [COORD_WIDTH-1:0] c_imag;
  } met_point_t;

  // One result.
  typedef struct packed {
    logic [CNT_W-1:0] iteration_count;
    logic             escaped;
    logic             in_cardioid;
  } met_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture a point and set up the result flags
    logic mul;       // register the squares and cross product of z
    logic msum;      // register |c|^2 and the cardioid factor
    logic cmul;      // register the cardioid product
    logic card_set;  // mark the point as inside the cardioid
    logic step;      // count one iteration and advance z
    logic out_load;  // copy the finished result to the output register
  } met_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic far;         // incoming point lies outside the +/-4 box
    logic card_hit;    // cardioid test holds
    logic limit_zero;  // iteration limit is zero
    logic escape;      // |z|^2 > 4 for the current z
    logic last;        // this iteration reaches the limit
  } met_sts_t;

endpackage

@@ rtl/mandelbrot_escape_time.sv @@
// Channel  | Signals                           | Direction
// ---------+-----------------------------------+----------
// cfg      | cfg_valid, cfg_ready, cfg_data    | in
// point    | point_valid, point_stall, point   | in
// result   | result_valid, result_stall, result| out
//
// A point outside the +/-4 box goes straight to DONE and then to the output register.
// Any other point runs the cardioid test in states SQ, MSUM, CMUL and CCMP; unless it
// is in the cardioid or the limit is zero, it iterates: multiply in IMUL, then add and
// escape check in ICHK. DONE loads the output register, then a new point can transfer.
// Reset is synchronous and sets the iteration limit to 256. While a stalled result
// holds the output register, a finished point waits and point_stall stays high; the
// configuration port is always ready.
//
// Top level of the Mandelbrot escape-time block.
// Depends on met_pkg, met_ctrl and met_dp.
module mandelbrot_escape_time import met_pkg::*; #(
  parameter int FRAC_BITS = MET_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic              point_valid,
  output logic              point_stall,
  input  met_point_t        point,
  output logic              result_valid,
  input  logic              result_stall,
  output met_result_t       result
);

  met_cmd_t cmd;
  met_sts_t sts;

  // The limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  // Sequencer.
  met_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Arithmetic and result register.
  met_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .point    (point),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule

@@ rtl/met_ctrl.sv @@
// Sequencer of the escape-time block: cardioid test, then the iteration loop.
// Depends on met_pkg and mandelbrot_escape_time_macros.svh.
`include "mandelbrot_escape_time_macros.svh"

module met_ctrl import met_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     point_valid,
  output logic     point_stall,
  output logic     result_valid,
  input  logic     result_stall,
  input  met_sts_t sts,
  output met_cmd_t cmd
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SQ   = 8'b0000_0010,
    ST_MSUM = 8'b0000_0100,
    ST_CMUL = 8'b0000_1000,
    ST_CCMP = 8'b0001_0000,
    ST_IMUL = 8'b0010_0000,
    ST_ICHK = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } met_state_t;

  met_state_t state;
  met_state_t state_next;

  // A point is taken only while no other point is in work.
  assign point_stall = (state != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (point_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.far ? ST_DONE : ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.mul    = 1'b1;
        state_next = ST_MSUM;
      end
      ST_MSUM: begin
        cmd.msum   = 1'b1;
        state_next = ST_CMUL;
      end
      ST_CMUL: begin
        cmd.cmul   = 1'b1;
        state_next = ST_CCMP;
      end
      ST_CCMP: begin
        if (sts.card_hit) begin
          cmd.card_set = 1'b1;
          state_next   = ST_DONE;
        end else if (sts.limit_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_IMUL;
        end
      end
      ST_IMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ICHK;
      end
      ST_ICHK: begin
        cmd.step   = 1'b1;
        state_next = (sts.escape || sts.last) ? ST_DONE : ST_IMUL;
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The output register holds a result until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  `MET_ASSERT_IMP(a_out_slot_free, clk, rst, cmd.out_load, !result_valid || !result_stall, "result overwritten while stalled")
  `MET_ASSERT_NXT(a_accept_start, clk, rst, point_valid && !point_stall, state == ST_SQ || state == ST_DONE, "bad state after point transfer")

endmodule

@@ rtl/met_dp.sv @@
// Datapath of the escape-time block: three multipliers, z registers, counter.
// Depends on met_pkg and mandelbrot_escape_time_macros.svh.
`include "mandelbrot_escape_time_macros.svh"

module met_dp import met_pkg::*; #(
  parameter int FRAC_BITS = MET_FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  met_cmd_t          cmd,
  output met_sts_t          sts,
  input  met_point_t        point,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_data,
  output met_result_t       result
);

  // z stays inside (-8, 8) until it escapes, so FRAC_BITS + 4 bits hold it.
  localparam int ZW = FRAC_BITS + 4;
  localparam int EW = ((COORD_WIDTH > ZW) ? COORD_WIDTH : ZW) + 1;
  localparam int PW = 2 * ZW;
  localparam int SW = FRAC_BITS + 7;
  localparam int QW = SW + 1;
  localparam int XW = FRAC_BITS + 8;
  localparam int LW = FRAC_BITS + 5;
  localparam int RW = SW + 2;

  localparam logic signed [EW-1:0] FOUR_E     = EW'(4) << FRAC_BITS;
  localparam logic signed [EW-1:0] NEG_FOUR_E = -FOUR_E;
  localparam logic        [QW-1:0] FOUR_Q     = QW'(4) << FRAC_BITS;
  localparam logic signed [ZW-1:0] THREE_Z    = ZW'(3) << FRAC_BITS;
  localparam logic signed [LW-1:0] RHS_C      = LW'(3) << (FRAC_BITS - 5);

  logic signed [EW-1:0]  cr_ext;
  logic signed [EW-1:0]  ci_ext;
  logic                  far_in;
  logic                  far_hit;
  logic [CNT_W-1:0]      max_iter;
  logic signed [ZW-1:0]  cr;
  logic signed [ZW-1:0]  ci;
  logic signed [ZW-1:0]  zr;
  logic signed [ZW-1:0]  zi;
  logic signed [PW-1:0]  pxx;
  logic signed [PW-1:0]  pyy;
  logic signed [PW-1:0]  pxy;
  logic [FRAC_BITS-1:0]  m;
  logic                  m_big;
  logic signed [ZW-1:0]  t;
  logic [CNT_W-1:0]      count;
  logic                  esc;
  logic                  card;
  logic signed [ZW-1:0]  op_a;
  logic signed [ZW-1:0]  op_b;
  logic [SW-1:0]         sqr;
  logic [SW-1:0]         sqi;
  logic [QW-1:0]         qsum;
  logic signed [XW-1:0]  zxy;
  logic signed [LW-1:0]  lhs;
  logic signed [LW-1:0]  rhs;
  logic signed [RW-1:0]  zr_wide;
  logic signed [XW:0]    zi_wide;
  logic [CNT_W-1:0]      count_inc;

  // Points outside the +/-4 box escape at once unless the iteration limit is zero.
  assign cr_ext  = {{(EW-COORD_WIDTH){point.c_real[COORD_WIDTH-1]}}, point.c_real};
  assign ci_ext  = {{(EW-COORD_WIDTH){point.c_imag[COORD_WIDTH-1]}}, point.c_imag};
  assign far_in  = (cr_ext >= FOUR_E) || (cr_ext <= NEG_FOUR_E) ||
                   (ci_ext >= FOUR_E) || (ci_ext <= NEG_FOUR_E);
  assign far_hit = far_in && (max_iter != '0);

  // Limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      max_iter <= cfg_data;
    end
  end

  // Third multiplier serves the cross term and the cardioid product.
  assign op_a = cmd.cmul ? $signed({4'b0000, m}) : zr;
  assign op_b = cmd.cmul ? t : zi;

  // Registered products.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pxx <= zr * zr;
      pyy <= zi * zi;
    end
    if (cmd.mul || cmd.cmul) begin
      pxy <= op_a * op_b;
    end
  end

  // Floors of the scaled products are plain bit slices.
  assign sqr   = pxx[FRAC_BITS+SW-1:FRAC_BITS];
  assign sqi   = pyy[FRAC_BITS+SW-1:FRAC_BITS];
  assign qsum  = {1'b0, sqr} + {1'b0, sqi};
  assign zxy   = pxy[FRAC_BITS+XW-2:FRAC_BITS-1];
  assign lhs   = pxy[FRAC_BITS+LW-1:FRAC_BITS];
  assign rhs   = RHS_C - {cr[ZW-1], cr};

  // Cardioid factors; |c|^2 >= 1 always fails the test.
  always_ff @(posedge clk) begin
    if (cmd.msum) begin
      m     <= qsum[FRAC_BITS-1:0];
      m_big <= |qsum[QW-1:FRAC_BITS];
      t     <= $signed({1'b0, qsum[FRAC_BITS-1:0], 3'b000}) - THREE_Z;
    end
  end

  // Next z from the registered squares and cross term.
  assign zr_wide = $signed({2'b00, sqr}) - $signed({2'b00, sqi}) +
                   $signed({{(RW-ZW){cr[ZW-1]}}, cr});
  assign zi_wide = $signed({zxy[XW-1], zxy}) +
                   $signed({{(XW+1-ZW){ci[ZW-1]}}, ci});
  assign count_inc = count + CNT_W'(1);

  // Point, z and result flags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr    <= cr_ext[ZW-1:0];
      ci    <= ci_ext[ZW-1:0];
      zr    <= cr_ext[ZW-1:0];
      zi    <= ci_ext[ZW-1:0];
      count <= far_hit ? CNT_W'(1) : '0;
      esc   <= far_hit;
      card  <= 1'b0;
    end else begin
      if (cmd.card_set) begin
        card <= 1'b1;
      end
      if (cmd.step) begin
        zr    <= zr_wide[ZW-1:0];
        zi    <= zi_wide[ZW-1:0];
        count <= count_inc;
        esc   <= sts.escape;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.iteration_count <= count;
      result.escaped         <= esc;
      result.in_cardioid     <= card;
    end
  end

  // Status to the controller.
  assign sts.far        = far_in;
  assign sts.card_hit   = !m_big && (lhs <= rhs);
  assign sts.limit_zero = (max_iter == '0);
  assign sts.escape     = (qsum > FOUR_Q);
  assign sts.last       = (count_inc == max_iter);

  `MET_ASSERT_IMP(a_step_below_limit, clk, rst, cmd.step, count < max_iter, "iteration past the limit")
  `MET_ASSERT_IMP(a_card_zero_count, clk, rst, cmd.out_load && card, count == '0 && !esc, "cardioid result with iterations")

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for mandelbrot_escape_time: directed and random points
// against a fixed-point escape-time predictor, mostly idling both channels at random.
// Depends on met_pkg and the mandelbrot_escape_time RTL.
module tb_top;
  import met_pkg::*;

  localparam int FB = MET_FRAC_BITS;
  localparam int unsigned MAX_IDLE = 12;
  localparam int unsigned WATCHDOG_LIMIT = 500000;
  localparam int unsigned END_FLUSH = 32;
  localparam int unsigned PHASE_POINTS = 180;
  localparam int unsigned EXP_DEPTH = 8;

  typedef logic signed [127:0] wide_t;

  // One pending expectation: the point that was sent and its predicted result.
  typedef struct {
    met_point_t  pt;
    met_result_t res;
  } escape_entry_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;
  logic             point_valid;
  logic             point_stall;
  met_point_t       point;
  logic             result_valid;
  logic             result_stall = 1'b0;
  met_result_t      result;

  // Ring of expectations: written at each point transfer, read at each result transfer.
  escape_entry_t    expected_escapes[EXP_DEPTH];
  int unsigned      sent_count = 0;
  int unsigned      checked_count = 0;
  logic [CNT_W-1:0] active_limit;
  bit               idle_on;
  int unsigned      mismatch_count = 0;
  int unsigned      result_seq = 0;
  int unsigned      stall_left = 0;
  int unsigned      quiet_cycles = 0;

  mandelbrot_escape_time u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Free-running clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Floor of a*b / 2^sh, exact at this width.
  function automatic wide_t mul_floor(input wide_t a, input wide_t b, input int sh);
    return (a * b) >>> sh;
  endfunction

  // Escape-time result for one point under the given iteration limit.
  function automatic met_result_t predict_escape(input met_point_t p,
                                                 input logic [CNT_W-1:0] limit);
    wide_t       cr, ci, four, m, lhs, rhs, zr, zi, zr2, zi2, nr;
    int unsigned count;
    met_result_t r;
    cr    = $signed(p.c_real);
    ci    = $signed(p.c_imag);
    four  = wide_t'(4) <<< FB;
    r     = '0;
    count = 0;
    // Points outside the +/-4 box escape at once unless no iteration is allowed.
    if (cr >= four || cr <= -four || ci >= four || ci <= -four) begin
      if (limit != 0) begin
        r.iteration_count = CNT_W'(1);
        r.escaped         = 1'b1;
      end
      return r;
    end
    // Main cardioid test on |c|^2.
    m   = mul_floor(cr, cr, FB) + mul_floor(ci, ci, FB);
    lhs = mul_floor(m, 8 * m - (wide_t'(3) <<< FB), FB);
    rhs = (wide_t'(3) <<< (FB - 5)) - cr;
    if (lhs <= rhs) begin
      r.in_cardioid = 1'b1;
      return r;
    end
    // Iterate z = z^2 + c from zero until escape or the limit.
    zr  = '0;
    zi  = '0;
    zr2 = '0;
    zi2 = '0;
    while (count < limit) begin
      nr    = zr2 - zi2 + cr;
      zi    = mul_floor(zr, zi, FB - 1) + ci;
      zr    = nr;
      count = count + 1;
      zr2   = mul_floor(zr, zr, FB);
      zi2   = mul_floor(zi, zi, FB);
      if (zr2 + zi2 > four) begin
        r.escaped = 1'b1;
        break;
      end
    end
    r.iteration_count = CNT_W'(count);
    return r;
  endfunction

  function automatic met_point_t point_at(input logic [COORD_WIDTH-1:0] re,
                                          input logic [COORD_WIDTH-1:0] im);
    met_point_t p;
    p.c_real = re;
    p.c_imag = im;
    return p;
  endfunction

  // Random point: mostly inside the interesting region, some noise and edge cases.
  function automatic met_point_t random_point();
    met_point_t                p;
    int unsigned               kind;
    logic [COORD_WIDTH-1:0]    edge_val;
    kind     = $urandom_range(9, 0);
    edge_val = $urandom_range(1, 0) ? 32'h4000_0000 : 32'hC000_0000;
    edge_val = edge_val + 32'($urandom_range(4, 0)) - 32'd2;
    p.c_real = 32'($urandom_range(32'h3000_0000, 0)) - 32'h2400_0000;
    p.c_imag = 32'($urandom_range(32'h3000_0000, 0)) - 32'h1800_0000;
    case (kind)
      0, 1: begin
        p.c_real = $urandom;
        p.c_imag = $urandom;
      end
      8: begin
        // Close to the cusp of the cardioid, where escape is slow.
        p.c_real = 32'h0400_0000 + 32'($urandom_range(32'h0020_0000, 0)) - 32'h0010_0000;
        p.c_imag = 32'($urandom_range(32'h0020_0000, 0)) - 32'h0010_0000;
      end
      9: begin
        // On either side of the +/-4 box edge.
        if ($urandom_range(1, 0)) begin
          p.c_real = edge_val;
        end else begin
          p.c_imag = edge_val;
        end
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Send one point and record its expected result at the transfer.
  task automatic send_point(input met_point_t p);
    int unsigned   gap;
    escape_entry_t entry;
    gap = idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
    if (gap != 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_valid <= 1'b1;
    point       <= p;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    entry.pt  = p;
    entry.res = predict_escape(p, active_limit);
    expected_escapes[sent_count % EXP_DEPTH] = entry;
    sent_count++;
  endtask

  // Stop sending and wait until every expected result has been transferred.
  task automatic drain_results();
    point_valid <= 1'b0;
    @(posedge clk);
    while (sent_count != checked_count) @(posedge clk);
  endtask

  // Write the iteration limit; only called while the block is idle.
  task automatic write_limit(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid    <= 1'b0;
    active_limit = value;
  endtask

  // The reset limit of 256 applies before any write.
  task automatic test_default_limit();
    send_point(point_at(32'h0000_0000, 32'h0000_0000));
    send_point(point_at(32'hF000_0000, 32'h0000_0000));
    send_point(point_at(32'h0400_0000, 32'h0000_0000));
    send_point(point_at(32'h0428_F5C2, 32'h0000_0000));
    send_point(point_at(32'hF400_0000, 32'h0199_999A));
    drain_results();
  endtask

  // Coordinate extremes and both sides of the +/-4 box.
  task automatic test_far_points();
    send_point(point_at(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_point(point_at(32'h8000_0000, 32'h8000_0000));
    send_point(point_at(32'h4000_0000, 32'h0000_0000));
    send_point(point_at(32'hC000_0000, 32'h0000_0000));
    send_point(point_at(32'h0000_0000, 32'h4000_0000));
    send_point(point_at(32'h0000_0000, 32'hC000_0000));
    send_point(point_at(32'h3FFF_FFFF, 32'h0000_0000));
    send_point(point_at(32'h0000_0000, 32'hC000_0001));
    drain_results();
  endtask

  // Orbits that sit exactly on |z| = 2 or cycle without escaping.
  task automatic test_boundary_orbits();
    send_point(point_at(32'h2000_0000, 32'h0000_0000));
    send_point(point_at(32'hE000_0000, 32'h0000_0000));
    send_point(point_at(32'h0000_0000, 32'h1000_0000));
    send_point(point_at(32'h0000_0000, 32'hF000_0000));
    drain_results();
  endtask

  // A zero limit runs no iteration, not even for far points.
  task automatic test_limit_zero();
    write_limit(CNT_W'(0));
    send_point(point_at(32'h1000_0000, 32'h0000_0000));
    send_point(point_at(32'h7FFF_FFFF, 32'h0000_0000));
    send_point(point_at(32'h0000_0000, 32'h0000_0000));
    drain_results();
  endtask

  // A limit of one stops late escapes after one iteration; a far point still escapes.
  task automatic test_limit_one();
    write_limit(CNT_W'(1));
    send_point(point_at(32'h0800_0000, 32'h0000_0000));
    send_point(point_at(32'h2000_0000, 32'h0000_0000));
    send_point(point_at(32'h8000_0000, 32'h0000_0000));
    drain_results();
  endtask

  // The largest limit with one bounded orbit and one slow escape.
  task automatic test_limit_max();
    write_limit({CNT_W{1'b1}});
    send_point(point_at(32'hF000_0000, 32'h0000_0000));
    send_point(point_at(32'h0428_F5C2, 32'h0000_0000));
    drain_results();
  endtask

  // One phase of random points under a single limit.
  task automatic test_random_points(input logic [CNT_W-1:0] limit, input bit idling,
                                    input int unsigned count);
    write_limit(limit);
    idle_on = idling;
    repeat (count) send_point(random_point());
    drain_results();
    idle_on = 1'b1;
  endtask

  // Result side: random stalls, and a field-by-field check of every transfer.
  always @(posedge clk) begin
    int unsigned   hold;
    escape_entry_t want;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (result_valid && !result_stall) begin
      result_seq++;
      if (sent_count == checked_count) begin
        report_mismatch($sformatf("result %0d with no point pending", result_seq));
      end else begin
        want = expected_escapes[checked_count % EXP_DEPTH];
        checked_count++;
        if (result.iteration_count !== want.res.iteration_count) begin
          report_mismatch($sformatf("c=(%h,%h) iteration_count %0d, expected %0d",
            want.pt.c_real, want.pt.c_imag, result.iteration_count,
            want.res.iteration_count));
        end
        if (result.escaped !== want.res.escaped) begin
          report_mismatch($sformatf("c=(%h,%h) escaped %b, expected %b",
            want.pt.c_real, want.pt.c_imag, result.escaped, want.res.escaped));
        end
        if (result.in_cardioid !== want.res.in_cardioid) begin
          report_mismatch($sformatf("c=(%h,%h) in_cardioid %b, expected %b",
            want.pt.c_real, want.pt.c_imag, result.in_cardioid, want.res.in_cardioid));
        end
      end
      hold = idle_on ? $urandom_range(MAX_IDLE, 0) : 0;
      stall_left   <= hold;
      result_stall <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= (stall_left > 1);
    end
  end

  // Watchdog: end the run if no transfer happens for too long.
  always @(posedge clk) begin
    if ((point_valid && !point_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("mandelbrot_escape_time test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    point_valid    <= 1'b0;
    point          <= '0;
    active_limit   = MAX_ITER_RESET;
    idle_on        = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_limit();
    test_far_points();
    test_boundary_orbits();
    test_limit_zero();
    test_limit_one();
    test_limit_max();

    test_random_points(CNT_W'(256), 1'b1, PHASE_POINTS);
    test_random_points(CNT_W'(1), 1'b1, PHASE_POINTS);
    test_random_points(CNT_W'(0), 1'b1, PHASE_POINTS);
    test_random_points(CNT_W'(2), 1'b1, PHASE_POINTS);
    test_random_points(CNT_W'($urandom_range(64, 3)), 1'b1, PHASE_POINTS);
    test_random_points(CNT_W'(1023), 1'b1, PHASE_POINTS);
    test_random_points(CNT_W'(256), 1'b0, PHASE_POINTS);
    test_random_points(CNT_W'($urandom_range(999, 65)), 1'b1, PHASE_POINTS);

    // Let any stray result show up before the verdict.
    drain_results();
    repeat (END_FLUSH) @(posedge clk);
    if (sent_count != checked_count) begin
      report_mismatch($sformatf("%0d results never arrived", sent_count - checked_count));
    end
    if (mismatch_count == 0) begin
      $display("mandelbrot_escape_time test passed");
    end else begin
      $display("mandelbrot_escape_time test failed");
    end
    $finish;
  end

endmodule

@@ mandelbrot_escape_time.f @@
+incdir+rtl
rtl/met_pkg.sv
rtl/met_ctrl.sv
rtl/met_dp.sv
rtl/mandelbrot_escape_time.sv
tb/sv/tb_top.sv
